/* src/phist_pkg.sv */
// Package for the pixel intensity histogram.
// Holds the shared constants, request codes and the internal operation type.
// No dependencies.
package phist_pkg;

	// Default sizes handed to the top level parameters.
	localparam int NUM_BINS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 24;

	// Fixed field widths and internal sizes.
	localparam int PIX_BITS = 8;
	localparam int NUM_CH   = 3;
	localparam int Q_DEPTH  = 4;

	// Channel slots inside an operation.
	localparam int CH_ZERO  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	// Request codes on the input channel.
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_COUNT = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_COUNT,
		OP_READ
	} op_kind_t;

	typedef enum logic {
		BK_CLEAR,
		BK_RUN
	} bk_state_t;

	// One classified operation passed from the front to the back.
	typedef struct packed {
		op_kind_t                           kind;
		logic [NUM_CH-1:0]                  en;
		logic [NUM_CH-1:0][PIX_BITS-1:0]    bin;
	} op_t;

endpackage

/* src/phist_if.sv */
// Handshake interfaces for the histogram request and result channels.
// Depends on phist_pkg for the pixel field width.
interface phist_req_if;
	import phist_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [PIX_BITS-1:0] gray_or_blue;
	logic [PIX_BITS-1:0] green;
	logic [PIX_BITS-1:0] red;
	logic [PIX_BITS-1:0] read_bin;

	modport source (output valid, req_type, gray_or_blue, green, red, read_bin, input ready);
	modport sink (input valid, req_type, gray_or_blue, green, red, read_bin, output ready);
endinterface

interface phist_rsp_if #(
	parameter int COUNT_BITS = phist_pkg::COUNT_BITS_DEF
);
	import phist_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_BITS-1:0]   bin_echo;
	logic [COUNT_BITS-1:0] count_gray_or_blue;
	logic [COUNT_BITS-1:0] count_green;
	logic [COUNT_BITS-1:0] count_red;

	modport source (output valid, bin_echo, count_gray_or_blue, count_green, count_red,
		input ready);
	modport sink (input valid, bin_echo, count_gray_or_blue, count_green, count_red,
		output ready);
endinterface

/* src/phist_front.sv */
// Front end: accepts request items, holds the color mode register and
// classifies each item into an operation for the queue. Uses phist_pkg, phist_if.
module phist_front #(
	parameter int NUM_BINS = phist_pkg::NUM_BINS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	phist_req_if.sink        request,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             full,
	output logic             push,
	output phist_pkg::op_t   push_op
);
	import phist_pkg::*;

	logic color_mode_q;
	logic keep;
	logic ok_zero, ok_green, ok_red, ok_read;

	// Color mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			color_mode_q <= cfg_wr_data;
		end
	end

	// A value counts only if it names an existing bin.
	assign ok_zero  = 32'(request.gray_or_blue) < NUM_BINS;
	assign ok_green = 32'(request.green) < NUM_BINS;
	assign ok_red   = 32'(request.red) < NUM_BINS;
	assign ok_read  = 32'(request.read_bin) < NUM_BINS;

	// Classify the item; the unused code is accepted and dropped.
	always_comb begin
		push_op.kind          = OP_COUNT;
		push_op.en            = '0;
		push_op.bin[CH_ZERO]  = request.gray_or_blue;
		push_op.bin[CH_GREEN] = request.green;
		push_op.bin[CH_RED]   = request.red;
		keep                  = 1'b1;
		unique case (request.req_type)
			REQ_CLEAR: begin
				push_op.kind = OP_CLEAR;
			end
			REQ_COUNT: begin
				push_op.en[CH_ZERO]  = ok_zero;
				push_op.en[CH_GREEN] = color_mode_q & ok_green;
				push_op.en[CH_RED]   = color_mode_q & ok_red;
			end
			REQ_READ: begin
				push_op.kind          = OP_READ;
				push_op.en            = {NUM_CH{ok_read}};
				push_op.bin[CH_ZERO]  = request.read_bin;
				push_op.bin[CH_GREEN] = request.read_bin;
				push_op.bin[CH_RED]   = request.read_bin;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign request.ready = !full;
	assign push          = request.valid && !full && keep;

endmodule

/* src/phist_queue.sv */
// Short operation queue between the front and the back end.
// Depends on phist_pkg for the operation type and depth.
module phist_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  phist_pkg::op_t push_op,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output phist_pkg::op_t head_op
);
	import phist_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	op_t           entries_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = cnt_q == CW'(Q_DEPTH);
	assign valid   = cnt_q != '0;
	assign head_op = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* src/phist_bank.sv */
// One channel's bin memory: one write port and one registered read port.
// No package dependency.
module phist_bank #(
	parameter int NUM_BINS   = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                        clk,
	input  logic [$clog2(NUM_BINS)-1:0] rd_addr,
	output logic [COUNT_BITS-1:0]       rd_data,
	input  logic                        wr_en,
	input  logic [$clog2(NUM_BINS)-1:0] wr_addr,
	input  logic [COUNT_BITS-1:0]       wr_data
);
	logic [COUNT_BITS-1:0] mem [NUM_BINS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; returns the old value on a same-edge write.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/phist_back.sv */
// Back end: runs operations against the three bin memories with a
// read-increment-write pipeline, clears by sweeping, and buffers results.
// Uses phist_pkg, phist_if and phist_bank.
module phist_back #(
	parameter int NUM_BINS   = phist_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = phist_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  phist_pkg::op_t q_op,
	output logic           pop,
	phist_rsp_if.source    result
);
	import phist_pkg::*;

	localparam int AW = $clog2(NUM_BINS);

	bk_state_t state_q, state_d;
	logic [AW-1:0] clr_addr_q, clr_addr_d;
	logic          clearing;
	logic          rd_ok;

	// Second stage: memory data is back.
	logic vld_s2;
	op_t  op_s2;

	// Last write per channel, forwarded to the op right behind it.
	logic                  fw_vld_s3  [NUM_CH];
	logic [AW-1:0]         fw_addr_s3 [NUM_CH];
	logic [COUNT_BITS-1:0] fw_data_s3 [NUM_CH];

	logic [COUNT_BITS-1:0] rd_data [NUM_CH];
	logic [COUNT_BITS-1:0] fwd     [NUM_CH];
	logic [COUNT_BITS-1:0] inc     [NUM_CH];
	logic [COUNT_BITS-1:0] rsp_cnt [NUM_CH];
	logic                  wr_en   [NUM_CH];
	logic [AW-1:0]         wr_addr [NUM_CH];
	logic [COUNT_BITS-1:0] wr_data [NUM_CH];

	// Two-entry result buffer.
	logic [PIX_BITS-1:0]   ob_bin_q [2];
	logic [COUNT_BITS-1:0] ob_c0_q  [2];
	logic [COUNT_BITS-1:0] ob_cg_q  [2];
	logic [COUNT_BITS-1:0] ob_cr_q  [2];
	logic                  ob_wr_q, ob_rd_q;
	logic [1:0]            ob_cnt_q;
	logic                  ob_push, ob_pop;
	logic                  s2_read;

	assign clearing = state_q == BK_CLEAR;
	assign s2_read  = vld_s2 && op_s2.kind == OP_READ;

	// A read issues only when its result is sure to find room.
	assign rd_ok = (ob_cnt_q == 2'd0) || (ob_cnt_q == 2'd1 && !s2_read);

	// State register and sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
		end
	end

	// Next state: sweep the memories, or issue the head operation.
	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		pop        = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_addr_q == AW'(NUM_BINS - 1)) begin
					state_d    = BK_RUN;
					clr_addr_d = '0;
				end else begin
					clr_addr_d = clr_addr_q + 1'b1;
				end
			end
			BK_RUN: begin
				if (q_valid && (q_op.kind != OP_READ || rd_ok)) begin
					pop = 1'b1;
					if (q_op.kind == OP_CLEAR) begin
						state_d = BK_CLEAR;
					end
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	// Pipeline control; a clear leaves a bubble behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= pop && q_op.kind != OP_CLEAR;
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= q_op;
	end

	// Per-channel memory, forwarding, saturating increment and write back.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		phist_bank #(
			.NUM_BINS   (NUM_BINS),
			.COUNT_BITS (COUNT_BITS)
		) u_bank (
			.clk     (clk),
			.rd_addr (AW'(q_op.bin[c])),
			.rd_data (rd_data[c]),
			.wr_en   (wr_en[c]),
			.wr_addr (wr_addr[c]),
			.wr_data (wr_data[c])
		);

		assign fwd[c] = (fw_vld_s3[c] && fw_addr_s3[c] == AW'(op_s2.bin[c]))
			? fw_data_s3[c] : rd_data[c];
		assign inc[c] = (fwd[c] == {COUNT_BITS{1'b1}}) ? fwd[c]
			: fwd[c] + COUNT_BITS'(1);
		assign rsp_cnt[c] = op_s2.en[c] ? fwd[c] : '0;

		assign wr_en[c]   = clearing || (vld_s2 && op_s2.kind == OP_COUNT && op_s2.en[c]);
		assign wr_addr[c] = clearing ? clr_addr_q : AW'(op_s2.bin[c]);
		assign wr_data[c] = clearing ? '0 : inc[c];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fw_vld_s3[c] <= 1'b0;
			end else begin
				fw_vld_s3[c] <= !clearing && vld_s2 && op_s2.kind == OP_COUNT
					&& op_s2.en[c];
			end
		end

		always_ff @(posedge clk) begin
			fw_addr_s3[c] <= AW'(op_s2.bin[c]);
			fw_data_s3[c] <= inc[c];
		end
	end

	// Result buffer.
	assign ob_push = s2_read;
	assign ob_pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (ob_push) begin
			ob_bin_q[ob_wr_q] <= op_s2.bin[CH_ZERO];
			ob_c0_q[ob_wr_q]  <= rsp_cnt[CH_ZERO];
			ob_cg_q[ob_wr_q]  <= rsp_cnt[CH_GREEN];
			ob_cr_q[ob_wr_q]  <= rsp_cnt[CH_RED];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (ob_push) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			if (ob_push && !ob_pop) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (ob_pop && !ob_push) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

	assign result.valid              = ob_cnt_q != 2'd0;
	assign result.bin_echo           = ob_bin_q[ob_rd_q];
	assign result.count_gray_or_blue = ob_c0_q[ob_rd_q];
	assign result.count_green        = ob_cg_q[ob_rd_q];
	assign result.count_red          = ob_cr_q[ob_rd_q];

endmodule

/* src/pixel_intensity_histogram.sv */
// Pixel intensity histogram top level: front end, operation queue, back end.
// Count items run at one item per cycle unless a clear sweep or a waiting read holds the back
// end; a read waits while the result buffer might lack room. A read moves through the queue,
// the second stage and the result buffer, each registered. A clear holds the back end while it
// sweeps one bin of each store per cycle; up to four items queue meanwhile. Reset starts the
// same sweep and sets the color mode to gray. Depends on phist_pkg, phist_if, submodules.
module pixel_intensity_histogram #(
	parameter int NUM_BINS   = phist_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = phist_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	phist_req_if.sink   request,
	phist_rsp_if.source result,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import phist_pkg::*;

	logic push, full, q_valid, pop;
	op_t  push_op, head_op;

	// Accept and classify items.
	phist_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.full        (full),
		.push        (push),
		.push_op     (push_op)
	);

	// Decouple the front from the back.
	phist_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.valid   (q_valid),
		.pop     (pop),
		.head_op (head_op)
	);

	// Carry out operations on the bin memories.
	phist_back #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (head_op),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the pixel intensity histogram.
// Predicts every read result from its own copy of the three bin stores and checks each one.
// Depends on phist_pkg, the phist_req_if/phist_rsp_if interfaces and the top level.
`timescale 1ns / 100ps

module testbench;
	import phist_pkg::*;

	localparam int HIST_BINS      = NUM_BINS_DEF;
	localparam int CNT_W          = COUNT_BITS_DEF;
	localparam int SETTLE_CYCLES  = HIST_BINS + 16;
	localparam int WATCHDOG_LIMIT = 4000;

	// Request code that the block must ignore.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [PIX_BITS-1:0] c0;
		logic [PIX_BITS-1:0] cg;
		logic [PIX_BITS-1:0] cr;
		logic [PIX_BITS-1:0] rb;
	} pixel_req_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] bin;
		logic [CNT_W-1:0]    zero;
		logic [CNT_W-1:0]    green;
		logic [CNT_W-1:0]    red;
	} bin_counts_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	phist_req_if req_ch();
	phist_rsp_if #(.COUNT_BITS(CNT_W)) rsp_ch();

	pixel_intensity_histogram #(
		.NUM_BINS(HIST_BINS),
		.COUNT_BITS(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Predicted state of the block.
	logic [CNT_W-1:0] hist_zero[HIST_BINS];
	logic [CNT_W-1:0] hist_green[HIST_BINS];
	logic [CNT_W-1:0] hist_red[HIST_BINS];
	logic             color_mode_q;

	bin_counts_t expected_counts[$];
	int          fail_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Adds one to a bin unless it is out of range or already saturated.
	function automatic void bump_bin(ref logic [CNT_W-1:0] store[HIST_BINS],
			input logic [PIX_BITS-1:0] value);
		if (int'(value) < HIST_BINS && store[value] != {CNT_W{1'b1}}) begin
			store[value] = store[value] + 1'b1;
		end
	endfunction

	function automatic void clear_histogram();
		for (int i = 0; i < HIST_BINS; i++) begin
			hist_zero[i]  = '0;
			hist_green[i] = '0;
			hist_red[i]   = '0;
		end
	endfunction

	// Updates the predicted stores for one accepted item and queues any read result.
	function automatic void predict_request(input pixel_req_t it);
		bin_counts_t res;
		case (it.kind)
			REQ_CLEAR: begin
				clear_histogram();
			end
			REQ_COUNT: begin
				bump_bin(hist_zero, it.c0);
				if (color_mode_q) begin
					bump_bin(hist_green, it.cg);
					bump_bin(hist_red, it.cr);
				end
			end
			REQ_READ: begin
				res.bin = it.rb;
				if (int'(it.rb) < HIST_BINS) begin
					res.zero  = hist_zero[it.rb];
					res.green = hist_green[it.rb];
					res.red   = hist_red[it.rb];
				end else begin
					res.zero  = '0;
					res.green = '0;
					res.red   = '0;
				end
				expected_counts.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	// Presents one item, with a random idle gap first, and waits for its acceptance.
	task automatic send_item(input pixel_req_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= it.kind;
		req_ch.gray_or_blue <= it.c0;
		req_ch.green        <= it.cg;
		req_ch.red          <= it.cr;
		req_ch.read_bin     <= it.rb;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(it);
	endtask

	task automatic send_pixel(input logic [7:0] c0, input logic [7:0] cg, input logic [7:0] cr);
		send_item('{kind: REQ_COUNT, c0: c0, cg: cg, cr: cr, rb: 8'($urandom)});
	endtask

	task automatic send_read(input logic [7:0] rb);
		send_item('{kind: REQ_READ, c0: 8'($urandom), cg: 8'($urandom), cr: 8'($urandom),
			rb: rb});
	endtask

	task automatic send_clear();
		send_item('{kind: REQ_CLEAR, c0: 8'($urandom), cg: 8'($urandom), cr: 8'($urandom),
			rb: 8'($urandom)});
	endtask

	// Holds the sender back until every outstanding read result has come.
	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
	endtask

	// Drains, then lets a possible clear sweep and queued counts finish.
	task automatic drain_and_settle();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_color_mode(input logic mode);
		drain_and_settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		color_mode_q = mode;
	endtask

	// Stores must read zero after reset, in gray mode.
	task automatic test_reset_state();
		send_read(8'd0);
		send_read(8'd255);
	endtask

	// Gray mode counts channel zero only; green and red stay untouched.
	task automatic test_gray_counting();
		send_pixel(8'd0, 8'hFF, 8'hFF);
		send_pixel(8'd255, 8'h00, 8'hAA);
		send_pixel(8'd255, 8'h55, 8'h00);
		send_read(8'd0);
		send_read(8'd255);
		send_read(8'd170);
	endtask

	// Color mode counts one bin in each of the three stores.
	task automatic test_color_counting();
		write_color_mode(1'b1);
		send_pixel(8'd0, 8'd255, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd7);
		send_pixel(8'd9, 8'd9, 8'd9);
		send_read(8'd0);
		send_read(8'd255);
		send_read(8'd128);
		send_read(8'd9);
	endtask

	// Back in gray mode, green and red keep what color mode left there.
	task automatic test_mode_switch();
		write_color_mode(1'b0);
		send_pixel(8'd255, 8'd0, 8'd128);
		send_read(8'd0);
		send_read(8'd255);
	endtask

	// The unused request code changes nothing and returns nothing.
	task automatic test_unused_code();
		send_item('{kind: REQ_UNUSED, c0: 8'd9, cg: 8'd9, cr: 8'd9, rb: 8'd9});
		send_read(8'd9);
	endtask

	// A clear zeroes every bin of all three stores.
	task automatic test_clear();
		send_clear();
		send_read(8'd0);
		send_read(8'd255);
	endtask

	// Random pixels, reads, clears and unused codes under one mode and idling profile.
	task automatic test_random_traffic(input int n_items, input logic mode,
			input int idle_pct, input int stall_pct);
		logic [7:0] hot[8];
		int         pick;
		pixel_req_t it;
		write_color_mode(mode);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		foreach (hot[i]) hot[i] = 8'($urandom);
		for (int n = 0; n < n_items; n++) begin
			if (n == n_items / 2) begin
				pause_until_drained();
			end
			// Half of the values come from eight hot bins so that counts build up.
			it.c0 = ($urandom_range(1) != 0) ? hot[$urandom_range(7)] : 8'($urandom);
			it.cg = ($urandom_range(1) != 0) ? hot[$urandom_range(7)] : 8'($urandom);
			it.cr = ($urandom_range(1) != 0) ? hot[$urandom_range(7)] : 8'($urandom);
			it.rb = ($urandom_range(1) != 0) ? hot[$urandom_range(7)] : 8'($urandom);
			pick  = $urandom_range(99);
			if (pick < 2) begin
				it.kind = REQ_CLEAR;
			end else if (pick < 5) begin
				it.kind = REQ_UNUSED;
			end else if (pick < 70) begin
				it.kind = REQ_COUNT;
			end else begin
				it.kind = REQ_READ;
			end
			send_item(it);
		end
	endtask

	// Result receiver: random stalls and a field by field check against the oldest prediction.
	always @(posedge clk) begin : result_check
		bin_counts_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual bin %0d", $time,
					rsp_ch.bin_echo);
				fail_count++;
			end else begin
				want = expected_counts.pop_front();
				if (rsp_ch.bin_echo !== want.bin) begin
					$display("%0t: bin_echo mismatch: expected %0d, actual %0d", $time,
						want.bin, rsp_ch.bin_echo);
					fail_count++;
				end
				if (rsp_ch.count_gray_or_blue !== want.zero) begin
					$display("%0t: count_gray_or_blue mismatch at bin %0d: expected %0d, actual %0d",
						$time, want.bin, want.zero, rsp_ch.count_gray_or_blue);
					fail_count++;
				end
				if (rsp_ch.count_green !== want.green) begin
					$display("%0t: count_green mismatch at bin %0d: expected %0d, actual %0d",
						$time, want.bin, want.green, rsp_ch.count_green);
					fail_count++;
				end
				if (rsp_ch.count_red !== want.red) begin
					$display("%0t: count_red mismatch at bin %0d: expected %0d, actual %0d",
						$time, want.bin, want.red, rsp_ch.count_red);
					fail_count++;
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("%0t: timeout, no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	// Main sequence.
	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_CLEAR;
		req_ch.gray_or_blue = '0;
		req_ch.green        = '0;
		req_ch.red          = '0;
		req_ch.read_bin     = '0;
		rsp_ch.ready        = 1'b0;
		fail_count          = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		color_mode_q        = 1'b0;
		clear_histogram();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_gray_counting();
		test_color_counting();
		test_mode_switch();
		test_unused_code();
		test_clear();

		test_random_traffic(290, 1'b1, 0, 0);
		test_random_traffic(290, 1'b0, 58, 0);
		test_random_traffic(290, 1'b1, 0, 58);
		test_random_traffic(290, 1'b0, 11, 11);

		drain_and_settle();
		if (fail_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
src/phist_pkg.sv
src/phist_if.sv
src/phist_front.sv
src/phist_queue.sv
src/phist_bank.sv
src/phist_back.sv
src/pixel_intensity_histogram.sv
tb/testbench.sv
